// ===== rtl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg: shared types, constants and functions of the cache tag store
// Default geometry, fixed field widths, access codes and elaboration helpers.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int WAYS_DEF         = 8;
  localparam int LINE_BYTES_DEF   = 64;
  localparam int CACHE_KBYTES_DEF = 32;
  localparam int ADDRESS_BITS_DEF = 40;

  localparam int KBYTE       = 1024;
  localparam int EXT_W       = 64;  // address working width, above any ADDRESS_BITS
  localparam int VICTIM_W    = 3;
  localparam int FILL_WAY_W  = 3;
  localparam int WAY_MAX_W   = 4;   // enough for up to 16 ways
  localparam int COUNT_W     = 32;
  localparam int VICTIM_STEPS = 8;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic hit;
    logic filled;
  } lookup_status_t;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x > 1) begin
        x = x >> 1;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Reduce a victim code below the way count by repeated subtraction
  function automatic logic [WAY_MAX_W-1:0] reduce_victim(input logic [VICTIM_W-1:0] v,
                                                         input int ways);
    logic [WAY_MAX_W-1:0] r;
    logic [WAY_MAX_W-1:0] w;
    r = WAY_MAX_W'(v);
    w = WAY_MAX_W'(ways);
    for (int i = 0; i < VICTIM_STEPS; i++) begin
      if (ways <= (1 << WAY_MAX_W) - 1 && r >= w) begin
        r = r - w;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/sact_tag_ram.sv =====
// ----------------------------------------------------------------------------
// sact_tag_ram: set-wide tag and valid memory
// One row per set holding valid bit and tag of every way; registered read.
// ----------------------------------------------------------------------------
module sact_tag_ram
  import sact_pkg::*;
#(
  parameter int ADDR_W = 6,
  parameter int ROW_W  = 232
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: a write in the same cycle is forwarded by the caller
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sact_lookup.sv =====
// ----------------------------------------------------------------------------
// sact_lookup: tag compare and way selection for one set
// Matches the tag against every valid way, picks the fill way and builds the
// updated row.
// ----------------------------------------------------------------------------
module sact_lookup
  import sact_pkg::*;
#(
  parameter int WAYS  = 8,
  parameter int TAG_W = 28,
  parameter int WAY_W = 3
) (
  input  logic [WAYS*(TAG_W+1)-1:0] row,
  input  logic                      row_live,
  input  logic [TAG_W-1:0]          tag,
  input  logic                      func,
  input  logic [WAY_W-1:0]          victim,
  output lookup_status_t            status,
  output logic [WAY_W-1:0]          fill_way,
  output logic [WAYS*(TAG_W+1)-1:0] row_next
);

  localparam int ENT_W = TAG_W + 1;

  logic [WAYS-1:0]  valid;
  logic [WAYS-1:0]  match;
  logic             free_found;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid[w] = row_live & row[w*ENT_W + TAG_W];
      match[w] = valid[w] && (row[w*ENT_W +: TAG_W] == tag);
    end
  end

  // lowest-numbered invalid way
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    status.hit    = |match;
    status.filled = !(|match) && (func == FUNC_READ);
    fill_way      = '0;
    if (status.filled) begin
      fill_way = free_found ? free_way : victim;
    end
  end

  // rebuild the row with live valid bits, install the tag on a fill
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_next[w*ENT_W + TAG_W]  = valid[w];
      row_next[w*ENT_W +: TAG_W] = row[w*ENT_W +: TAG_W];
      if (status.filled && fill_way == WAY_W'(w)) begin
        row_next[w*ENT_W + TAG_W]  = 1'b1;
        row_next[w*ENT_W +: TAG_W] = tag;
      end
    end
  end

endmodule

// ===== rtl/set_assoc_cache_tag_store.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store: tag store of a set-associative cache
// Looks up one access per cycle, fills on read misses and keeps saturating
// hit and miss totals.
//
//   channel   ports                                         handshake
//   input     address, func, victim_way                     start, busy
//   result    hit, filled, fill_way, hit_total, miss_total  done (strobe)
//
// One item is accepted every cycle while busy is low. The tag RAM read and
// the lookup stage register load when an item is accepted, and the result
// registers and done load from the lookup stage.
// A fill is forwarded to an item of the same set whose tag RAM read met its write.
// Reset clears the counters and the per-set written flags at once; no
// clearing pass, so busy is high only while rst is.
// The receiver cannot stall: done is high for one cycle per item.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store
  import sact_pkg::*;
#(
  parameter int WAYS         = WAYS_DEF,
  parameter int LINE_BYTES   = LINE_BYTES_DEF,
  parameter int CACHE_KBYTES = CACHE_KBYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic                    func,
  input  logic [VICTIM_W-1:0]     victim_way,
  output logic                    done,
  output logic                    hit,
  output logic                    filled,
  output logic [FILL_WAY_W-1:0]   fill_way,
  output logic [COUNT_W-1:0]      hit_total,
  output logic [COUNT_W-1:0]      miss_total
);

  localparam int SET_RAW   = (CACHE_KBYTES * KBYTE) / LINE_BYTES / WAYS;
  localparam int SET_COUNT = (SET_RAW > 0) ? SET_RAW : 1;
  localparam int OFF_BITS  = floor_log2(LINE_BYTES);
  localparam int IDX_BITS  = floor_log2(SET_COUNT);
  localparam int IDX_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int TAG_RAW   = ADDRESS_BITS - OFF_BITS - IDX_BITS;
  localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W     = WAYS * (TAG_W + 1);
  localparam int SET_DEPTH = 1 << IDX_W;

  logic                 accept;
  logic [EXT_W-1:0]     addr_ext;
  logic [EXT_W-1:0]     tag_full;
  logic [IDX_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;
  logic [WAY_MAX_W-1:0] victim_red;

  logic                 s1_valid;
  logic [IDX_W-1:0]     s1_set;
  logic [TAG_W-1:0]     s1_tag;
  logic                 s1_func;
  logic [WAY_W-1:0]     s1_victim;
  logic                 s1_live;

  logic [SET_DEPTH-1:0] row_written;
  logic [ROW_W-1:0]     rd_row;
  logic                 fwd_valid;
  logic [IDX_W-1:0]     fwd_set;
  logic [ROW_W-1:0]     fwd_row;
  logic                 fwd_hit;
  logic [ROW_W-1:0]     cur_row;
  logic                 cur_live;

  lookup_status_t       st;
  logic [WAY_W-1:0]     lk_way;
  logic [WAY_MAX_W-1:0] lk_way_ext;
  logic [ROW_W-1:0]     row_next;
  logic                 wr_en;

  logic [COUNT_W-1:0]   hit_counter;
  logic [COUNT_W-1:0]   miss_counter;
  logic [COUNT_W-1:0]   hit_counter_next;
  logic [COUNT_W-1:0]   miss_counter_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // address split
  assign addr_ext = EXT_W'(address);
  assign tag_full = addr_ext >> (OFF_BITS + IDX_BITS);
  assign tag_in   = tag_full[TAG_W-1:0];

  generate
    if (IDX_BITS > 0) begin : g_idx
      assign set_in = addr_ext[OFF_BITS +: IDX_W];
    end else begin : g_no_idx
      assign set_in = '0;
    end
  endgenerate

  assign victim_red = reduce_victim(victim_way, WAYS);

  // lookup stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set    <= set_in;
      s1_tag    <= tag_in;
      s1_func   <= func;
      s1_victim <= victim_red[WAY_W-1:0];
      s1_live   <= row_written[set_in];
    end
  end

  sact_tag_ram #(
    .ADDR_W (IDX_W),
    .ROW_W  (ROW_W)
  ) u_tag_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (set_in),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (s1_set),
    .wr_data (row_next)
  );

  // take the row written last cycle when the read missed it
  assign fwd_hit  = fwd_valid && (fwd_set == s1_set);
  assign cur_row  = fwd_hit ? fwd_row : rd_row;
  assign cur_live = fwd_hit || s1_live;

  sact_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WAY_W (WAY_W)
  ) u_lookup (
    .row      (cur_row),
    .row_live (cur_live),
    .tag      (s1_tag),
    .func     (s1_func),
    .victim   (s1_victim),
    .status   (st),
    .fill_way (lk_way),
    .row_next (row_next)
  );

  assign wr_en = s1_valid && st.filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
      if (wr_en) begin
        row_written[s1_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_set <= s1_set;
      fwd_row <= row_next;
    end
  end

  // saturating totals
  always_comb begin
    hit_counter_next  = hit_counter;
    miss_counter_next = miss_counter;
    if (s1_valid) begin
      if (st.hit) begin
        if (hit_counter != '1) begin
          hit_counter_next = hit_counter + COUNT_W'(1);
        end
      end else if (miss_counter != '1) begin
        miss_counter_next = miss_counter + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter  <= '0;
      miss_counter <= '0;
      done         <= 1'b0;
    end else begin
      hit_counter  <= hit_counter_next;
      miss_counter <= miss_counter_next;
      done         <= s1_valid;
    end
  end

  assign lk_way_ext = WAY_MAX_W'(lk_way);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      hit        <= st.hit;
      filled     <= st.filled;
      fill_way   <= lk_way_ext[FILL_WAY_W-1:0];
      hit_total  <= hit_counter_next;
      miss_total <= miss_counter_next;
    end
  end

  a_hit_fill_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && filled))
    else $error("hit and fill reported together");

  a_way_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !filled) |-> (fill_way == '0))
    else $error("fill way nonzero without a fill");

  a_write_no_alloc: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_func == FUNC_WRITE) |-> !wr_en)
    else $error("write miss allocated a line");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> ((hit_counter + miss_counter) != $past(hit_counter + miss_counter))
                 || (hit_counter == '1) || (miss_counter == '1))
    else $error("access not counted");

endmodule

// ===== tb/sv/set_assoc_cache_tag_store_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_tb: self-checking bench for the cache tag store
// Drives a short table of directed accesses, then random accesses that
// concentrate on a few sets and tags so that hits, fills and victim
// replacement all happen. Every result is compared field by field with the
// expected row of the table where given, else with a tag-store model kept in the bench.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store_tb;
  import sact_pkg::*;

  localparam int ADDR_W       = ADDRESS_BITS_DEF;
  localparam int LINE_OFS_W   = $clog2(LINE_BYTES_DEF);
  localparam int SET_COUNT    = CACHE_KBYTES_DEF * KBYTE / LINE_BYTES_DEF / WAYS_DEF;
  localparam int SET_SEL_W    = $clog2(SET_COUNT);
  localparam int TAG_FIELD_W  = ADDR_W - LINE_OFS_W - SET_SEL_W;
  localparam int RANDOM_ITEMS = 480;
  localparam int MAX_GAP      = 19;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic                  hit;
    logic                  filled;
    logic [FILL_WAY_W-1:0] fill_way;
    logic [COUNT_W-1:0]    hit_total;
    logic [COUNT_W-1:0]    miss_total;
  } access_outcome_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic                func;
    logic [VICTIM_W-1:0] victim;
    logic                typed;
    access_outcome_t     outcome;
  } access_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ADDR_W-1:0]     address = '0;
  logic                  func = FUNC_READ;
  logic [VICTIM_W-1:0]   victim_way = '0;
  logic                  done;
  logic                  hit;
  logic                  filled;
  logic [FILL_WAY_W-1:0] fill_way;
  logic [COUNT_W-1:0]    hit_total;
  logic [COUNT_W-1:0]    miss_total;

  // bench copy of the tag store
  logic                   line_ok [SET_COUNT][WAYS_DEF];
  logic [TAG_FIELD_W-1:0] line_tags [SET_COUNT][WAYS_DEF];
  logic [COUNT_W-1:0]     hits_seen;
  logic [COUNT_W-1:0]     misses_seen;

  access_outcome_t        pending_outcomes [$];
  access_row_t            directed_rows [$];
  logic [SET_SEL_W-1:0]   hot_sets [4];
  logic [TAG_FIELD_W-1:0] hot_tags [12];
  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  bit                     idle_on = 1'b1;

  set_assoc_cache_tag_store dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .address    (address),
    .func       (func),
    .victim_way (victim_way),
    .done       (done),
    .hit        (hit),
    .filled     (filled),
    .fill_way   (fill_way),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic access_outcome_t lookup_and_fill(input logic [ADDR_W-1:0] addr,
                                                      input logic f,
                                                      input logic [VICTIM_W-1:0] v);
    access_outcome_t        o;
    logic [SET_SEL_W-1:0]   set_idx;
    logic [TAG_FIELD_W-1:0] line_tag;
    int                     chosen;
    o = '0;
    set_idx = addr[LINE_OFS_W +: SET_SEL_W];
    line_tag = addr[ADDR_W-1 -: TAG_FIELD_W];
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (line_ok[set_idx][w] && line_tags[set_idx][w] == line_tag) o.hit = 1'b1;
    end
    if (o.hit) begin
      if (hits_seen != '1) hits_seen = hits_seen + 1'b1;
    end else begin
      if (misses_seen != '1) misses_seen = misses_seen + 1'b1;
      if (f == FUNC_READ) begin
        chosen = int'(v) % WAYS_DEF;
        // prefer the lowest free way over the victim
        for (int w = WAYS_DEF - 1; w >= 0; w--) begin
          if (!line_ok[set_idx][w]) chosen = w;
        end
        line_ok[set_idx][chosen] = 1'b1;
        line_tags[set_idx][chosen] = line_tag;
        o.filled = 1'b1;
        o.fill_way = FILL_WAY_W'(chosen);
      end
    end
    o.hit_total = hits_seen;
    o.miss_total = misses_seen;
    return o;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 2) return raw[ADDR_W-1:0];
    return {hot_tags[$urandom_range(0, 11)], hot_sets[$urandom_range(0, 3)],
            raw[LINE_OFS_W-1:0]};
  endfunction

  function automatic int next_gap();
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  task automatic issue_access(input logic [ADDR_W-1:0] addr, input logic f,
                              input logic [VICTIM_W-1:0] v, input logic typed,
                              input access_outcome_t typed_outcome, input int gap);
    access_outcome_t predicted;
    start <= 1'b1;
    address <= addr;
    func <= f;
    victim_way <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = lookup_and_fill(addr, f, v);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    access_outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd1);
      end else begin
        want = pending_outcomes.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(hit));
        if (filled !== want.filled)
          report_mismatch("filled", 64'(want.filled), 64'(filled));
        if (fill_way !== want.fill_way)
          report_mismatch("fill_way", 64'(want.fill_way), 64'(fill_way));
        if (hit_total !== want.hit_total)
          report_mismatch("hit_total", 64'(want.hit_total), 64'(hit_total));
        if (miss_total !== want.miss_total)
          report_mismatch("miss_total", 64'(want.miss_total), 64'(miss_total));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAYS_DEF; w++) begin
        line_ok[s][w] = 1'b0;
        line_tags[s][w] = '0;
      end
    end
    hits_seen = '0;
    misses_seen = '0;

    // address, func, victim, typed, expected {hit, filled, way, hits, misses}
    directed_rows.push_back('{40'h00_0000_0000, FUNC_READ,  3'd0, 1'b1,
                              '{1'b0, 1'b1, 3'd0, 32'd0, 32'd1}});
    directed_rows.push_back('{40'h00_0000_0000, FUNC_READ,  3'd3, 1'b1,
                              '{1'b1, 1'b0, 3'd0, 32'd1, 32'd1}});
    directed_rows.push_back('{40'hFF_FFFF_FFFF, FUNC_WRITE, 3'd7, 1'b1,
                              '{1'b0, 1'b0, 3'd0, 32'd1, 32'd2}});
    directed_rows.push_back('{40'hFF_FFFF_FFFF, FUNC_READ,  3'd7, 1'b1,
                              '{1'b0, 1'b1, 3'd0, 32'd1, 32'd3}});
    directed_rows.push_back('{40'hFF_FFFF_FFFF, FUNC_WRITE, 3'd0, 1'b1,
                              '{1'b1, 1'b0, 3'd0, 32'd2, 32'd3}});
    // fill the rest of set 0, then hit, replace, write-miss in a full set
    directed_rows.push_back('{40'h00_0000_1000, FUNC_READ,  3'd1, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_2000, FUNC_READ,  3'd2, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_3000, FUNC_READ,  3'd3, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_4000, FUNC_READ,  3'd4, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_5000, FUNC_READ,  3'd5, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_6000, FUNC_READ,  3'd6, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_7000, FUNC_READ,  3'd7, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_003F, FUNC_READ,  3'd1, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_8000, FUNC_READ,  3'd5, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_5000, FUNC_READ,  3'd7, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_9000, FUNC_WRITE, 3'd2, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_803F, FUNC_READ,  3'd6, 1'b0, '0});
    directed_rows.push_back('{40'h00_0000_0040, FUNC_READ,  3'd6, 1'b0, '0});
    directed_rows.push_back('{40'hFF_FFFF_FFC0, FUNC_WRITE, 3'd4, 1'b0, '0});
    directed_rows.push_back('{40'h80_0000_0000, FUNC_READ,  3'd4, 1'b0, '0});

    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < 4; i++) hot_sets[i] = SET_SEL_W'($urandom);
    for (int i = 0; i < 12; i++) hot_tags[i] = TAG_FIELD_W'($urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_access(directed_rows[i].addr, directed_rows[i].func, directed_rows[i].victim,
                   directed_rows[i].typed, directed_rows[i].outcome, next_gap());
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // choose at random for each stretch whether to leave idle cycles between items
      if (n % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_ITEMS / 2) drain_results();
      issue_access(pick_address(), ($urandom_range(0, 9) < 3) ? FUNC_WRITE : FUNC_READ,
                   VICTIM_W'($urandom_range(0, 7)), 1'b0, '0, next_gap());
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
